// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/tfs_pkg.sv =====
package tfs_pkg;
  localparam int MaxOrderDef  = 2;
  localparam int ValueBitsDef = 32;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] REG_ORDER_NUM = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORDER_DEN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NUM0      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NUM1      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NUM2      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEN0      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DEN1      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DEN2      = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF_START,
    S_DIFF_WAIT,
    S_MAC_NUM,
    S_MAC_DEN,
    S_SUM_SAT,
    S_TOP_START,
    S_TOP_WAIT,
    S_EULER_MUL,
    S_EULER_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       diff_start;
    logic       diff_store;
    logic       mac_num;
    logic       mac_den;
    logic       sum_sat;
    logic       top_start;
    logic       top_store;
    logic       euler_mul;
    logic       euler_add;
    logic       out_load;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       top_zero;
    logic [3:0] nb;
    logic [3:0] na;
  } stat_t;
endpackage

// ===== src/tfs_if.sv =====
interface tfs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] input_value;
  logic [30:0] step_dt;
  modport source (output valid, input_value, step_dt, input ready);
  modport sink (input valid, input_value, step_dt, output ready);
endinterface

interface tfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] y_out;
  logic        div_fault;
  logic        saturated;
  modport source (output valid, y_out, div_fault, saturated, input ready);
  modport sink (input valid, y_out, div_fault, saturated, output ready);
endinterface

// ===== src/transfer_function_step.sv =====
// transfer_function_step: one forward-Euler step of B(s)/A(s), Q16.16.
// Input channel (in_): one beat carries input_value and step_dt; the block
//   takes a beat only when idle and works on one sample at a time.
// Result channel (out_): one beat per input beat with y_out, div_fault and
//   saturated, held in an output register until taken.
// Config port (cfg_): write registers 0..7 (orders, num and den coefs)
//   only while the block is idle.
// Orders are clamped to MAX_ORDER. Each input derivative and the top
//   coefficient divide use one shared 50-iteration radix-2 divider; the
//   sums take one term at a time and each Euler stage multiplies, then
//   adds. A zero top coefficient skips the divide and the Euler stages.
//   Input is ready again in the same cycle that out valid rises.
// A stalled receiver holds the result; the next sample is then taken and
//   processed, and waits to deliver until the held beat is taken.
// Reset (rst_n low, synchronous) clears the derivative chains, sets the
//   orders to zero and den_coef_0 to 1.0.
module transfer_function_step
  import tfs_pkg::*;
#(
  parameter int MAX_ORDER  = MaxOrderDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  tfs_in_if.sink      in_ch,
  tfs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;

  tfs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  tfs_datapath #(.MAX_ORDER(MAX_ORDER), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .cfg_we, .cfg_index, .cfg_data,
    .in_value(in_ch.input_value), .in_dt(in_ch.step_dt),
    .y_out(out_ch.y_out), .div_fault(out_ch.div_fault),
    .saturated(out_ch.saturated)
  );
endmodule

// ===== src/tfs_div.sv =====
// Signed Q16.16 divide: (num<<16)/den, truncating, saturated to 32 bits.
module tfs_div
  import tfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output logic        done,
  output logic signed [31:0] quo,
  output logic        clip
);
  localparam int NW = 50;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [32:0]   d_r;
  logic          neg_r, zero_r, nz_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW:0]   trial;
  logic [NW-1:0] mag;
  logic          ovf;

  always_comb begin
    trial = {rem_r[NW-1:0], n_r[NW-1]} - {{(NW-32){1'b0}}, d_r};
    rem_nxt = trial[NW] ? {rem_r[NW-1:0], n_r[NW-1]} : trial;
    q_nxt = {q_r[NW-2:0], ~trial[NW]};
    n_nxt = {n_r[NW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd1) && !start;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NW);
      end else if (busy_r) begin
        if (cnt_r == 6'd1) busy_r <= 1'b0;
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= NW'({(num[32] ? 33'(-num) : 33'(num)), 16'd0});
      d_r    <= den[32] ? 33'(-den) : 33'(den);
      zero_r <= (den == 33'sd0);
      nz_r   <= (num != 33'sd0);
      neg_r  <= (den == 33'sd0) ? num[32] : (num[32] ^ den[32]);
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  always_comb begin
    mag = q_r;
    ovf = 1'b0;
    if (zero_r) begin
      quo  = !nz_r ? 32'sd0 : (neg_r ? 32'sh80000000 : 32'sh7fffffff);
      clip = 1'b1;
    end else if (neg_r) begin
      ovf  = mag > {{(NW-32){1'b0}}, 32'h80000000};
      quo  = ovf ? 32'sh80000000 : 32'(-mag);
      clip = ovf;
    end else begin
      ovf  = mag > {{(NW-32){1'b0}}, 32'h7fffffff};
      quo  = ovf ? 32'sh7fffffff : 32'(mag);
      clip = ovf;
    end
  end

  assign done = done_r;
endmodule

// ===== src/tfs_datapath.sv =====
module tfs_datapath
  import tfs_pkg::*;
#(
  parameter int MAX_ORDER  = MaxOrderDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [31:0] in_value,
  input  logic [30:0] in_dt,
  output logic [31:0] y_out,
  output logic        div_fault,
  output logic        saturated
);
  localparam int VW = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
  localparam logic signed [63:0] HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;
  localparam int N = MAX_ORDER + 1;
  localparam int IW = $clog2(N);

  logic [1:0] onum_r, oden_r;
  logic signed [31:0] nc_r [N];
  logic signed [31:0] dc_r [N];
  logic signed [31:0] ud_r [N];
  logic signed [31:0] yd_r [N];
  logic signed [31:0] val_r;
  logic [30:0]        dt_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic               clip_r, fault_r;
  logic [31:0]        yo_r;
  logic               fo_r, so_r;

  logic [3:0] nb, na;
  logic [3:0] idx;
  logic [IW-1:0] ix, ixm1, ia;
  logic        top_zero;
  logic signed [32:0] dnum, dden;
  logic        dv_done, dv_clip;
  logic signed [31:0] dv_quo;
  logic signed [31:0] in_sat, quo_sat, cut_sat;
  logic        in_clip, quo_clip, cut_clip;
  logic signed [63:0] mac_term;
  logic signed [63:0] cut_in;

  function automatic logic signed [63:0] fl16(input logic signed [63:0] v);
    return v >>> 16;
  endfunction

  assign nb = (32'(onum_r) > MAX_ORDER) ? 4'(MAX_ORDER) : 4'(onum_r);
  assign na = (32'(oden_r) > MAX_ORDER) ? 4'(MAX_ORDER) : 4'(oden_r);
  assign idx = cmd.idx;
  assign ix = IW'(idx);
  assign ixm1 = IW'(idx - 4'd1);
  assign ia = IW'(na);
  assign top_zero = (dc_r[ia] == 32'sd0);

  always_comb begin
    dnum = 33'(val_r) - 33'(ud_r[ix]);
    dden = 33'($signed({1'b0, dt_r}));
    if (cmd.top_start) begin
      dnum = 33'($signed(acc_r[31:0]));
      dden = 33'(dc_r[ia]);
    end
  end

  tfs_div u_div (
    .clk, .rst_n, .start(cmd.diff_start | (cmd.top_start & !top_zero)),
    .num(dnum), .den(dden), .done(dv_done), .quo(dv_quo), .clip(dv_clip)
  );

  always_comb begin
    in_sat = $signed(in_value);
    in_clip = 1'b0;
    if (64'($signed(in_value)) > HI) begin
      in_sat = 32'(HI);
      in_clip = 1'b1;
    end else if (64'($signed(in_value)) < LO) begin
      in_sat = 32'(LO);
      in_clip = 1'b1;
    end
    quo_sat = dv_quo;
    quo_clip = dv_clip;
    if (64'(dv_quo) > HI) begin
      quo_sat = 32'(HI);
      quo_clip = 1'b1;
    end else if (64'(dv_quo) < LO) begin
      quo_sat = 32'(LO);
      quo_clip = 1'b1;
    end
    cut_in = 64'(yd_r[ixm1]) + fl16(prod_r);
    cut_sat = 32'(cut_in);
    cut_clip = 1'b0;
    if (cut_in > HI) begin
      cut_sat = 32'(HI);
      cut_clip = 1'b1;
    end else if (cut_in < LO) begin
      cut_sat = 32'(LO);
      cut_clip = 1'b1;
    end
    mac_term = fl16(64'(nc_r[ix]) * 64'(ud_r[ix]));
    if (cmd.mac_den) mac_term = -fl16(64'(dc_r[ix]) * 64'(yd_r[ix]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onum_r <= '0;
      oden_r <= '0;
      for (int i = 0; i < N; i++) begin
        nc_r[i] <= '0;
        dc_r[i] <= (i == 0) ? 32'sd65536 : 32'sd0;
        ud_r[i] <= '0;
        yd_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ORDER_NUM) onum_r <= cfg_data[1:0];
        else if (cfg_index == REG_ORDER_DEN) oden_r <= cfg_data[1:0];
        else if (cfg_index >= REG_NUM0 && cfg_index <= REG_NUM2) begin
          for (int i = 0; i < N; i++)
            if (32'(cfg_index - REG_NUM0) == i) nc_r[i] <= cfg_data;
        end else if (cfg_index >= REG_DEN0 && cfg_index <= REG_DEN2) begin
          for (int i = 0; i < N; i++)
            if (32'(cfg_index - REG_DEN0) == i) dc_r[i] <= cfg_data;
        end
      end
      // input chain: stored value k moves in as derivative k+1 leaves the divider
      for (int i = 0; i < N; i++) begin
        if (cmd.load && nb == 4'd0 && i == 0) ud_r[i] <= in_sat;
        if (cmd.diff_store) begin
          if (4'(i) == idx) ud_r[i] <= val_r;
          else if (4'(i) == idx + 4'd1 && idx + 4'd1 == nb) ud_r[i] <= quo_sat;
        end
        if (cmd.top_store && 4'(i) == na) yd_r[i] <= quo_sat;
        if (cmd.euler_add && 4'(i) == idx - 4'd1) yd_r[i] <= cut_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r    <= in_dt;
      acc_r   <= '0;
      fault_r <= 1'b0;
      val_r   <= in_sat;
      clip_r  <= in_clip;
    end else begin
      if (cmd.diff_store) begin
        val_r <= quo_sat;
        if (quo_clip) clip_r <= 1'b1;
      end
      if (cmd.mac_num || cmd.mac_den) acc_r <= acc_r + mac_term;
      if (cmd.euler_mul) prod_r <= 64'(yd_r[ix]) * 64'($signed({1'b0, dt_r}));
      if (cmd.euler_add && cut_clip) clip_r <= 1'b1;
      if (cmd.sum_sat) begin
        if (acc_r > HI) begin acc_r <= HI; clip_r <= 1'b1; end
        else if (acc_r < LO) begin acc_r <= LO; clip_r <= 1'b1; end
      end
      if (cmd.top_start && top_zero) fault_r <= 1'b1;
      if (cmd.top_store && quo_clip) clip_r <= 1'b1;
    end
    if (cmd.out_load) begin
      yo_r <= yd_r[0];
      fo_r <= fault_r;
      so_r <= clip_r;
    end
  end

  assign stat.div_done = dv_done;
  assign stat.top_zero = top_zero;
  assign stat.nb = nb;
  assign stat.na = na;
  assign y_out = yo_r;
  assign div_fault = fo_r;
  assign saturated = so_r;
endmodule

// ===== src/tfs_ctrl.sv =====
module tfs_ctrl
  import tfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  `include "assert_macros.svh"
  state_t state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.idx = idx_r;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_nxt = 4'd0;
          state_nxt = (stat.nb == 4'd0) ? S_MAC_NUM : S_DIFF_START;
        end
      end
      S_DIFF_START: begin
        cmd.diff_start = 1'b1;
        state_nxt = S_DIFF_WAIT;
      end
      S_DIFF_WAIT: begin
        if (stat.div_done) begin
          cmd.diff_store = 1'b1;
          idx_nxt = idx_r + 4'd1;
          state_nxt = (idx_r + 4'd1 == stat.nb) ? S_MAC_NUM : S_DIFF_START;
          if (idx_r + 4'd1 == stat.nb) idx_nxt = 4'd0;
        end
      end
      S_MAC_NUM: begin
        cmd.mac_num = 1'b1;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == stat.nb) begin
          idx_nxt = 4'd0;
          state_nxt = (stat.na == 4'd0) ? S_SUM_SAT : S_MAC_DEN;
        end
      end
      S_MAC_DEN: begin
        cmd.mac_den = 1'b1;
        idx_nxt = idx_r + 4'd1;
        if (idx_r + 4'd1 == stat.na) state_nxt = S_SUM_SAT;
      end
      S_SUM_SAT: begin
        cmd.sum_sat = 1'b1;
        state_nxt = S_TOP_START;
      end
      S_TOP_START: begin
        cmd.top_start = 1'b1;
        state_nxt = stat.top_zero ? S_OUT : S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        if (stat.div_done) begin
          cmd.top_store = 1'b1;
          idx_nxt = stat.na;
          state_nxt = (stat.na == 4'd0) ? S_OUT : S_EULER_MUL;
        end
      end
      S_EULER_MUL: begin
        cmd.euler_mul = 1'b1;
        state_nxt = S_EULER_ADD;
      end
      S_EULER_ADD: begin
        cmd.euler_add = 1'b1;
        idx_nxt = idx_r - 4'd1;
        state_nxt = (idx_r == 4'd1) ? S_OUT : S_EULER_MUL;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `ASSERT_NEXT(a_out_set, clk, rst_n, cmd.out_load, ov_r)
  `ASSERT_IMPL(a_one_div, clk, rst_n, cmd.diff_start, !cmd.top_start)
endmodule

// ===== test/transfer_function_step_tb.sv =====
module transfer_function_step_tb;
  import tfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int NUM_PHASES     = 12;
  localparam int BEATS_PER_PHASE = 120;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    logic [31:0] value;
    logic [30:0] dt;
    bit          drain;
  } sample_t;

  typedef struct {
    logic [31:0] y;
    logic        fault;
    logic        sat;
  } step_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  tfs_in_if  in_ch ();
  tfs_out_if out_ch ();

  transfer_function_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sample_t   sample_q[$];
  step_res_t y_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle;
  int        recv_idle;

  // shadow of block state and registers
  logic [1:0] ord_num, ord_den;
  longint     num_c[3], den_c[3];
  longint     in_d[3], out_d[3];
  bit         step_clip;

  function longint sat32(longint x);
    if (x > Q_MAX) begin
      step_clip = 1;
      return Q_MAX;
    end
    if (x < Q_MIN) begin
      step_clip = 1;
      return Q_MIN;
    end
    return x;
  endfunction

  function longint q_div(longint num, longint den);
    longint n;
    n = num * 65536;
    if (den == 0) begin
      step_clip = 1;
      if (n > 0) return Q_MAX;
      if (n < 0) return Q_MIN;
      return 0;
    end
    return sat32(n / den);
  endfunction

  function step_res_t euler_step(logic [31:0] u, logic [30:0] dtb);
    step_res_t r;
    longint v[3];
    longint dt, acc, top;
    int nb, na;
    step_clip = 0;
    nb = (ord_num > 2) ? 2 : ord_num;
    na = (ord_den > 2) ? 2 : ord_den;
    dt = longint'({33'b0, dtb});
    v[0] = longint'(signed'(u));
    for (int k = 0; k < nb; k++) v[k+1] = q_div(v[k] - in_d[k], dt);
    for (int k = 0; k <= nb; k++) in_d[k] = v[k];
    acc = 0;
    for (int k = 0; k <= nb; k++) acc += (num_c[k] * in_d[k]) >>> 16;
    for (int k = 0; k < na; k++) acc -= (den_c[k] * out_d[k]) >>> 16;
    acc = sat32(acc);
    top = den_c[na];
    r.fault = (top == 0);
    if (top != 0) begin
      out_d[na] = q_div(acc, top);
      for (int k = na; k > 0; k--)
        out_d[k-1] = sat32(out_d[k-1] + ((out_d[k] * dt) >>> 16));
    end
    r.y = out_d[0][31:0];
    r.sat = step_clip;
    return r;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 0;
      in_ch.input_value <= '0;
      in_ch.step_dt     <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle &&
          !(sample_q[0].drain && (y_q.size() != 0 || in_ch.valid))) begin
        in_ch.valid       <= 1;
        in_ch.input_value <= sample_q[0].value;
        in_ch.step_dt     <= sample_q[0].dt;
        void'(sample_q.pop_front());
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // accepted input beats feed the shadow model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      y_q = {y_q, euler_step(in_ch.input_value, in_ch.step_dt)};
  end

  always @(posedge clk) begin
    step_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (y_q.size() == 0) begin
        report("unexpected beat", out_ch.y_out, 32'h0);
      end else begin
        e = y_q.pop_front();
        if (out_ch.y_out !== e.y) report("y_out", out_ch.y_out, e.y);
        if (out_ch.div_fault !== e.fault)
          report("div_fault", 32'(out_ch.div_fault), 32'(e.fault));
        if (out_ch.saturated !== e.sat)
          report("saturated", 32'(out_ch.saturated), 32'(e.sat));
      end
    end
  end

  task cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == REG_ORDER_NUM) ord_num = d[1:0];
    else if (idx == REG_ORDER_DEN) ord_den = d[1:0];
    else if (idx >= REG_NUM0 && idx <= REG_NUM2) num_c[idx - REG_NUM0] = longint'(signed'(d));
    else den_c[idx - REG_DEN0] = longint'(signed'(d));
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task wait_idle();
    while (sample_q.size() != 0 || in_ch.valid || y_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 32'h1ffff)) - 32'h10000;
    endcase
  endfunction

  function sample_t rand_sample();
    sample_t s;
    case ($urandom_range(9))
      0: s.value = $urandom();
      1: s.value = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: s.value = 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
    endcase
    case ($urandom_range(9))
      0: s.dt = 31'($urandom());
      1: s.dt = 31'($urandom_range(1, 16));
      default: s.dt = 31'($urandom_range(32'h100, 32'h20000));
    endcase
    if (s.dt == 0) s.dt = 1;
    s.drain = ($urandom_range(49) == 0);
    return s;
  endfunction

  task automatic add_directed();
    logic [31:0] vals[5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00010000};
    logic [30:0] dts[4] = '{31'h1, 31'h7fffffff, 31'h0, 31'h10000};
    sample_t s;
    s.drain = 0;
    foreach (dts[j])
      foreach (vals[i]) begin
        s.value = vals[i];
        s.dt = dts[j];
        sample_q = {sample_q, s};
      end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 18;
    recv_idle = 64;
    ord_num = 0;
    ord_den = 0;
    for (int k = 0; k < 3; k++) begin
      num_c[k] = 0;
      den_c[k] = 0;
      in_d[k] = 0;
      out_d[k] = 0;
    end
    den_c[0] = 65536;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 4)
        0: begin send_idle = 18; recv_idle = 64; end
        1: begin send_idle = 64; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 1) begin
        cfg_write(REG_ORDER_NUM, 2);
        cfg_write(REG_ORDER_DEN, 2);
        cfg_write(REG_NUM0, 32'h00010000);
        cfg_write(REG_NUM1, 32'h00008000);
        cfg_write(REG_NUM2, 32'hffff0000);
        cfg_write(REG_DEN0, 32'h00010000);
        cfg_write(REG_DEN1, 32'h00020000);
        cfg_write(REG_DEN2, 32'h00010000);
        add_directed();
      end else if (p == 2) begin
        cfg_write(REG_ORDER_NUM, 3);
        cfg_write(REG_ORDER_DEN, 3);
        cfg_write(REG_NUM0, 32'h7fffffff);
        cfg_write(REG_NUM1, 32'h80000000);
        cfg_write(REG_NUM2, 32'h7fffffff);
        cfg_write(REG_DEN0, 32'h80000000);
        cfg_write(REG_DEN1, 32'h7fffffff);
        cfg_write(REG_DEN2, 32'h00000001);
      end else if (p == 3) begin
        cfg_write(REG_ORDER_NUM, 1);
        cfg_write(REG_ORDER_DEN, 1);
        cfg_write(REG_DEN1, 32'h0);
      end else if (p > 3) begin
        cfg_write(REG_ORDER_NUM, $urandom_range(3));
        cfg_write(REG_ORDER_DEN, $urandom_range(3));
        for (int k = 0; k < 3; k++) begin
          cfg_write(CfgIdxW'(REG_NUM0 + k), rand_coef());
          cfg_write(CfgIdxW'(REG_DEN0 + k), ($urandom_range(7) == 0) ? 32'h0 : rand_coef());
        end
      end
      for (int i = 0; i < BEATS_PER_PHASE; i++) sample_q = {sample_q, rand_sample()};
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/tfs_pkg.sv
src/tfs_if.sv
src/tfs_div.sv
src/tfs_datapath.sv
src/tfs_ctrl.sv
src/transfer_function_step.sv
test/transfer_function_step_tb.sv
